// ===== rtl/lnsc_pkg.sv =====
// lnsc_pkg: shared types and constants of the letterbox nearest scaler
// no dependencies
`timescale 1ns / 1ps
package lnsc_pkg;

  localparam int unsigned SOURCE_MAX_DIM_DEF = 256;
  localparam int unsigned TARGET_MAX_DIM_DEF = 4096;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned TDIM_RAW_W = 13;
  localparam int unsigned SDIM_RAW_W = 9;

  localparam logic [PIXEL_W-1:0] LETTERBOX_PIXEL = 32'hFF00_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_WIDTH  = 3'd0,
    CFG_TARGET_HEIGHT = 3'd1,
    CFG_SOURCE_WIDTH  = 3'd2,
    CFG_SOURCE_HEIGHT = 3'd3,
    CFG_BLUE_FIRST    = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_PICTURE   = 2'd0,
    ST_LETTERBOX = 2'd1,
    ST_OUTSIDE   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_VSTART, S_VWAIT, S_BOX, S_MUL,
    S_XSTART, S_XWAIT, S_YSTART, S_YWAIT, S_READ, S_RDATA, S_DONE
  } state_e;

endpackage

// ===== rtl/letterbox_nearest_scaler.sv =====
// letterbox_nearest_scaler: top level, source frame store and read sequencer
// depends on lnsc_pkg and lnsc_div
`timescale 1ns / 1ps
// usage
// - input channel: in_valid_i / in_stall_o carry one word: action, column, row,
//   pixel_in. a load word writes pixel_in into the source store and gives no
//   result; a read word gives exactly one result word
// - output channel: out_valid_o / out_stall_i carry pixel_out and status
// - configuration: cfg_we_i with cfg_idx_i and cfg_data_i; the user must write
//   only while the block is idle, the block itself does not enforce it
// - a scaled read runs the viewport, column and row divisions one after
//   another on a single bit-serial divider, one quotient bit a cycle, then
//   reads the store. a letterbox read runs only the viewport division, an
//   outside read none
// - one word is worked on at a time; the next word is taken the cycle after
//   the result is registered. while the result is stalled the next word may
//   already be taken and computed up to its final step
// - reset clears the control state and loads the register defaults; the
//   store is left undefined, and a read of a never loaded entry is undefined
module letterbox_nearest_scaler #(
  parameter int unsigned SOURCE_MAX_DIM = lnsc_pkg::SOURCE_MAX_DIM_DEF,
  parameter int unsigned TARGET_MAX_DIM = lnsc_pkg::TARGET_MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lnsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lnsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [lnsc_pkg::COORD_W-1:0]  column_i,
  input  logic [lnsc_pkg::COORD_W-1:0]  row_i,
  input  logic [lnsc_pkg::PIXEL_W-1:0]  pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lnsc_pkg::PIXEL_W-1:0]  pixel_out_o,
  output logic [1:0]                    status_o
);
  import lnsc_pkg::*;

  // clamped dimension widths, product/numerator width, divisor width, store index width, depth and address width
  localparam int unsigned TW = $clog2(TARGET_MAX_DIM + 1);
  localparam int unsigned SD = $clog2(SOURCE_MAX_DIM + 1);
  localparam int unsigned NW = TW + SD;
  localparam int unsigned DW = (TW > SD) ? TW : SD;
  localparam int unsigned SI = $clog2(SOURCE_MAX_DIM);
  localparam int unsigned DEPTH = SOURCE_MAX_DIM * SOURCE_MAX_DIM;
  localparam int unsigned AW = $clog2(DEPTH);

  // configuration registers, kept raw and clamped on use
  logic [TDIM_RAW_W-1:0] tw_raw_q, th_raw_q;
  logic [SDIM_RAW_W-1:0] sw_raw_q, sh_raw_q;
  logic                  blue_first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_raw_q     <= TDIM_RAW_W'(256);
      th_raw_q     <= TDIM_RAW_W'(256);
      sw_raw_q     <= SDIM_RAW_W'(256);
      sh_raw_q     <= SDIM_RAW_W'(256);
      blue_first_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TARGET_WIDTH:  tw_raw_q     <= cfg_data_i[TDIM_RAW_W-1:0];
        CFG_TARGET_HEIGHT: th_raw_q     <= cfg_data_i[TDIM_RAW_W-1:0];
        CFG_SOURCE_WIDTH:  sw_raw_q     <= cfg_data_i[SDIM_RAW_W-1:0];
        CFG_SOURCE_HEIGHT: sh_raw_q     <= cfg_data_i[SDIM_RAW_W-1:0];
        CFG_BLUE_FIRST:    blue_first_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  logic [TW-1:0] tw, th;
  logic [SD-1:0] sw, sh;

  always_comb begin
    if (tw_raw_q == '0) tw = TW'(1);
    else if (32'(tw_raw_q) > TARGET_MAX_DIM) tw = TW'(TARGET_MAX_DIM);
    else tw = TW'(tw_raw_q);
    if (th_raw_q == '0) th = TW'(1);
    else if (32'(th_raw_q) > TARGET_MAX_DIM) th = TW'(TARGET_MAX_DIM);
    else th = TW'(th_raw_q);
    if (sw_raw_q == '0) sw = SD'(1);
    else if (32'(sw_raw_q) > SOURCE_MAX_DIM) sw = SD'(SOURCE_MAX_DIM);
    else sw = SD'(sw_raw_q);
    if (sh_raw_q == '0) sh = SD'(1);
    else if (32'(sh_raw_q) > SOURCE_MAX_DIM) sh = SD'(SOURCE_MAX_DIM);
    else sh = SD'(sh_raw_q);
  end

  // source store
  logic [PIXEL_W-1:0] store_mem [DEPTH];
  logic [PIXEL_W-1:0] rd_data_q;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;

  state_e state_q, state_d;

  logic                  in_accept;
  logic [COORD_W-1:0]    col_q, row_q;
  logic                  a_le_b;
  logic                  a_le_b_q;
  logic [NW-1:0]         prod_a_q, prod_b_q;
  logic [TW-1:0]         vw_q, vh_q;
  logic [TW-1:0]         dx_q, dy_q;
  logic [NW-1:0]         mx_q, my_q;
  logic [SI-1:0]         sx_q, sy_q;
  logic [PIXEL_W-1:0]    res_pix_q, res_pix_d;
  status_e               res_st_q, res_st_d;
  logic                  out_valid_q;
  logic [PIXEL_W-1:0]    pixel_out_q;
  status_e               status_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign wr_en = in_accept && (action_i == ACT_LOAD) &&
                 (32'(column_i) < SOURCE_MAX_DIM) && (32'(row_i) < SOURCE_MAX_DIM);
  assign wr_addr = AW'(row_i[SI-1:0]) * AW'(SOURCE_MAX_DIM) + AW'(column_i[SI-1:0]);
  assign rd_addr = AW'(sy_q) * AW'(SOURCE_MAX_DIM) + AW'(sx_q);

  // loads are taken only in idle, so a read never overlaps a write in flight
  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[wr_addr] <= pixel_in_i;
    rd_data_q <= store_mem[rd_addr];
  end

  // shared divider
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [NW-1:0] div_quo;

  lnsc_div #(.NumW(NW), .DenW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // which side of the viewport spans the full target
  assign a_le_b = (prod_a_q <= prod_b_q);

  // viewport side from the quotient: at least one, at most the target side
  logic [TW-1:0] vq_clamped;
  logic [TW-1:0] vq_limit;
  assign vq_limit = a_le_b_q ? th : tw;
  always_comb begin
    if (div_quo == '0) vq_clamped = TW'(1);
    else if (div_quo > NW'(vq_limit)) vq_clamped = vq_limit;
    else vq_clamped = TW'(div_quo);
  end

  // scaled index, clamped to the store
  logic [SI-1:0] sq_clamped;
  assign sq_clamped = (div_quo >= NW'(SOURCE_MAX_DIM)) ? SI'(SOURCE_MAX_DIM - 1)
                                                       : SI'(div_quo);

  // letterbox offsets and inside test
  logic [TW-1:0] vx, vy;
  logic          in_view;
  assign vx = (tw - vw_q) >> 1;
  assign vy = (th - vh_q) >> 1;
  assign in_view = (32'(col_q) >= 32'(vx)) && (32'(col_q) < 32'(vx) + 32'(vw_q)) &&
                   (32'(row_q) >= 32'(vy)) && (32'(row_q) < 32'(vy) + 32'(vh_q));

  always_comb begin
    state_d   = state_q;
    in_stall_o = 1'b1;
    div_start = 1'b0;
    div_num   = mx_q;
    div_den   = DW'(vw_q);
    res_pix_d = res_pix_q;
    res_st_d  = res_st_q;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && action_i == ACT_READ) state_d = S_PREP;
      end
      S_PREP: begin
        if (32'(col_q) >= 32'(tw) || 32'(row_q) >= 32'(th)) begin
          res_pix_d = '0;
          res_st_d  = ST_OUTSIDE;
          state_d   = S_DONE;
        end else begin
          state_d = S_VSTART;
        end
      end
      S_VSTART: begin
        div_start = 1'b1;
        div_num   = a_le_b ? prod_a_q : prod_b_q;
        div_den   = a_le_b ? DW'(sw) : DW'(sh);
        state_d   = S_VWAIT;
      end
      S_VWAIT: if (div_done) state_d = S_BOX;
      S_BOX: begin
        if (in_view) begin
          state_d = S_MUL;
        end else begin
          res_pix_d = LETTERBOX_PIXEL;
          res_st_d  = ST_LETTERBOX;
          state_d   = S_DONE;
        end
      end
      S_MUL: state_d = S_XSTART;
      S_XSTART: begin
        div_start = 1'b1;
        div_num   = mx_q;
        div_den   = DW'(vw_q);
        state_d   = S_XWAIT;
      end
      S_XWAIT: if (div_done) state_d = S_YSTART;
      S_YSTART: begin
        div_start = 1'b1;
        div_num   = my_q;
        div_den   = DW'(vh_q);
        state_d   = S_YWAIT;
      end
      S_YWAIT: if (div_done) state_d = S_READ;
      S_READ: state_d = S_RDATA;
      S_RDATA: begin
        res_pix_d = blue_first_q ? {rd_data_q[31:24], rd_data_q[7:0],
                                    rd_data_q[15:8], rd_data_q[23:16]}
                                 : rd_data_q;
        res_st_d  = ST_PICTURE;
        state_d   = S_DONE;
      end
      S_DONE: if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    res_pix_q <= res_pix_d;
    res_st_q  <= res_st_d;
    if (in_accept) begin
      col_q <= column_i;
      row_q <= row_i;
    end
    if (state_q == S_PREP) begin
      prod_a_q <= NW'(tw) * NW'(sh);
      prod_b_q <= NW'(th) * NW'(sw);
    end
    if (state_q == S_VSTART) a_le_b_q <= a_le_b;
    if (state_q == S_VWAIT && div_done) begin
      if (a_le_b_q) begin
        vw_q <= tw;
        vh_q <= vq_clamped;
      end else begin
        vw_q <= vq_clamped;
        vh_q <= th;
      end
    end
    if (state_q == S_BOX) begin
      dx_q <= TW'(32'(col_q) - 32'(vx));
      dy_q <= TW'(32'(row_q) - 32'(vy));
    end
    if (state_q == S_MUL) begin
      mx_q <= NW'(dx_q) * NW'(sw);
      my_q <= NW'(dy_q) * NW'(sh);
    end
    if (state_q == S_XWAIT && div_done) sx_q <= sq_clamped;
    if (state_q == S_YWAIT && div_done) sy_q <= sq_clamped;
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      pixel_out_q <= res_pix_q;
      status_q    <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_OUTSIDE) |-> pixel_out_q == '0)
    else $error("outside word with nonzero pixel");
  a_letterbox_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_LETTERBOX) |-> pixel_out_q == LETTERBOX_PIXEL)
    else $error("letterbox word not opaque black");
  a_view_in_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BOX) |-> (vw_q <= tw && vh_q <= th && vw_q != '0 && vh_q != '0))
    else $error("viewport outside target");
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_IDLE) else $error("store written while busy");
`endif

endmodule

// ===== rtl/lnsc_div.sv =====
// lnsc_div: restoring bit-serial unsigned divider, one quotient bit per cycle
// no dependencies (no imports needed)
`timescale 1ns / 1ps
module lnsc_div #(
  parameter int unsigned NumW = 22,
  parameter int unsigned DenW = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [DenW:0]   rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done longer than one cycle");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> !start_i) else $error("divider restarted while running");
`endif

endmodule
